### src/pair_square_distance_inverse_core_defines.svh
`ifndef PAIR_SQUARE_DISTANCE_INVERSE_CORE_DEFINES_SVH
`define PAIR_SQUARE_DISTANCE_INVERSE_CORE_DEFINES_SVH
// assertion helpers
`ifndef NO_ASSERTIONS
`define PSD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PSD_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define PSD_ASSERT(label, clk, rst_n, prop)
`define PSD_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### src/psdi_pkg.sv
`default_nettype none
package psdi_pkg;
  localparam int unsigned DistW = 34;
  localparam int unsigned WordW = 32;
  localparam int unsigned RecipStages = 33;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};
  localparam logic [WordW-1:0] EpsReset = 32'd1;

  typedef enum logic [0:0] {
    CfgEps   = 1'b0,
    CfgRange = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [DistW-1:0] d;
    logic             in_range;
    logic             keep_new;
    logic [DistW-1:0] prior;
  } dist_res_t;

  typedef struct packed {
    logic [WordW-1:0] inverse_square_dist;
    logic [DistW-1:0] square_dist;
  } psdi_out_t;
endpackage
`default_nettype wire

### src/pair_square_distance_inverse_core.sv
`default_nettype none
// Streaming pair distance unit: one node pair may be started every cycle
// (busy stays low); each result appears on done_o after registered stages
// for differences, squares and sum and a one-bit-per-stage reciprocal
// divider (a load stage and 33 quotient stages).
// Results cannot be stalled; the receiver must capture each transaction on
// its done_o cycle.
`include "pair_square_distance_inverse_core_defines.svh"
module pair_square_distance_inverse_core #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [COORD_WIDTH-1:0] node_x_i,
  input  wire logic [COORD_WIDTH-1:0] node_y_i,
  input  wire logic [COORD_WIDTH-1:0] other_x_i,
  input  wire logic [COORD_WIDTH-1:0] other_y_i,
  input  wire logic [31:0]            edge_weight_i,
  input  wire logic [33:0]            prior_square_dist_i,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [0:0]             cfg_index_i,
  input  wire logic [33:0]            cfg_data_i,
  output logic                        done_o,
  output psdi_pkg::psdi_out_t         result_o
);
  import psdi_pkg::*;

  logic [WordW-1:0] eps_q;
  logic [DistW-1:0] range_q;
  logic             dvld;
  dist_res_t        dres;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q   <= EpsReset;
      range_q <= DistMax;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgEps:   eps_q <= cfg_data_i[WordW-1:0];
        CfgRange: range_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  psdi_dist #(.CoordW(COORD_WIDTH)) u_dist (
    .clk_i, .rst_ni,
    .valid_i(start),
    .node_x_i(node_x_i), .node_y_i(node_y_i),
    .other_x_i(other_x_i), .other_y_i(other_y_i),
    .edge_weight_i, .prior_i(prior_square_dist_i),
    .eps_i(eps_q), .range_i(range_q),
    .valid_o(dvld), .res_o(dres)
  );

  psdi_recip u_recip (
    .clk_i, .rst_ni, .valid_i(dvld), .res_i(dres),
    .valid_o(done_o), .out_o(result_o)
  );

  `PSD_ASSERT(a_never_busy, clk_i, rst_ni, !busy)
  `PSD_ASSERT(a_done_sat, clk_i, rst_ni,
    done_o |-> (result_o.square_dist <= DistMax))
  `PSD_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_ready_o)
endmodule
`default_nettype wire

### src/psdi_dist.sv
`default_nettype none
module psdi_dist #(
  parameter int unsigned CoordW = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  input  wire logic signed [CoordW-1:0] node_x_i,
  input  wire logic signed [CoordW-1:0] node_y_i,
  input  wire logic signed [CoordW-1:0] other_x_i,
  input  wire logic signed [CoordW-1:0] other_y_i,
  input  wire logic [31:0]             edge_weight_i,
  input  wire logic [33:0]             prior_i,
  input  wire logic [31:0]             eps_i,
  input  wire logic [33:0]             range_i,
  output logic                         valid_o,
  output psdi_pkg::dist_res_t          res_o
);
  import psdi_pkg::*;
  localparam int unsigned MagW = CoordW;
  localparam int unsigned SqW = 2 * MagW;
  localparam int unsigned SumW = SqW + 1;

  logic [2:0]            vld_q;
  logic [MagW-1:0]       dx_q, dy_q;
  logic [SqW-1:0]        sx_q, sy_q;
  logic [DistW-1:0]      d_q;
  logic                  w1_q, w2_q, w3_q;
  logic [DistW-1:0]      p1_q, p2_q, p3_q;
  logic signed [CoordW:0] ex, ey;
  logic [CoordW:0]       ax, ay;
  logic [SumW-1:0]       sum;
  logic [DistW-1:0]      d_sat;

  assign ex = {node_x_i[CoordW-1], node_x_i} - {other_x_i[CoordW-1], other_x_i};
  assign ey = {node_y_i[CoordW-1], node_y_i} - {other_y_i[CoordW-1], other_y_i};
  assign ax = ex[CoordW] ? -ex : ex;
  assign ay = ey[CoordW] ? -ey : ey;
  assign sum = {1'b0, sx_q} + {1'b0, sy_q};

  // saturate the exact sum into the distance width
  always_comb begin
    if (SumW > DistW) begin
      d_sat = (sum > SumW'(DistMax)) ? DistMax : DistW'(sum);
    end else begin
      d_sat = DistW'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // magnitude of the difference fits in CoordW bits as unsigned
  always_ff @(posedge clk_i) begin
    dx_q <= ax[MagW-1:0];
    dy_q <= ay[MagW-1:0];
    w1_q <= edge_weight_i > eps_i;
    p1_q <= prior_i;
    sx_q <= dx_q * dx_q;
    sy_q <= dy_q * dy_q;
    w2_q <= w1_q;
    p2_q <= p1_q;
    d_q  <= d_sat;
    w3_q <= w2_q;
    p3_q <= p2_q;
  end

  assign valid_o = vld_q[2];
  assign res_o.d = d_q;
  assign res_o.in_range = (d_q > DistW'(eps_i)) && (d_q <= range_i);
  assign res_o.keep_new = w3_q;
  assign res_o.prior = p3_q;
endmodule
`default_nettype wire

### src/psdi_recip.sv
`default_nettype none
`include "pair_square_distance_inverse_core_defines.svh"
module psdi_recip (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire psdi_pkg::dist_res_t res_i,
  output logic                     valid_o,
  output psdi_pkg::psdi_out_t      out_o
);
  import psdi_pkg::*;
  localparam int unsigned RemW = DistW + 1;
  localparam int unsigned QW = RecipStages;

  // restoring division of 2^32 + d/2 by d, one quotient bit a stage
  logic [RecipStages:0]  vld_q;
  logic [RemW-1:0]       rem_q [RecipStages+1];
  logic [QW-1:0]         quo_q [RecipStages+1];
  logic [DistW-1:0]      div_q [RecipStages+1];
  logic                  ok_q  [RecipStages+1];
  logic [DistW-1:0]      sq_q  [RecipStages+1];
  logic [QW:0]           numer;

  // the top numerator bit seeds the remainder; it is only set when d >= 2^33,
  // so the remainder starts below the divisor and no quotient bit is lost
  assign numer = (QW+1)'({1'b1, 32'd0}) + (QW+1)'(res_i.d >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[RecipStages-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= RemW'(numer[QW]);
    quo_q[0] <= numer[QW-1:0];
    div_q[0] <= res_i.d;
    ok_q[0]  <= res_i.in_range && (res_i.d != '0);
    sq_q[0]  <= res_i.keep_new ? res_i.d : res_i.prior;
  end

  for (genvar s = 0; s < RecipStages; s++) begin : g_stage
    logic [RemW:0] sh;
    logic [RemW:0] diff;
    assign sh = {rem_q[s], quo_q[s][QW-1]};
    assign diff = sh - {2'b00, div_q[s]};
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= diff[RemW] ? sh[RemW-1:0] : diff[RemW-1:0];
      quo_q[s+1] <= {quo_q[s][QW-2:0], ~diff[RemW]};
      div_q[s+1] <= div_q[s];
      ok_q[s+1]  <= ok_q[s];
      sq_q[s+1]  <= sq_q[s];
    end
  end

  logic [QW-1:0] q;
  assign q = quo_q[RecipStages];
  assign valid_o = vld_q[RecipStages];
  assign out_o.inverse_square_dist = !ok_q[RecipStages] ? '0 :
                                     (q[QW-1] ? {WordW{1'b1}} : q[WordW-1:0]);
  assign out_o.square_dist = sq_q[RecipStages];

  `PSD_ASSERT_NEXT(a_vld_flow, clk_i, rst_ni, valid_i, vld_q[0])
  `PSD_ASSERT(a_zero_out, clk_i, rst_ni,
    (valid_o && !ok_q[RecipStages]) |-> (out_o.inverse_square_dist == '0))
  `PSD_ASSERT(a_no_zero_div, clk_i, rst_ni, (vld_q[0] && ok_q[0]) |-> (div_q[0] != '0))
endmodule
`default_nettype wire
